// ===== hw/rtl/slfr_pkg.sv =====
`timescale 1ns / 1ps
// slfr_pkg: constants and the result type of the sync/length frame receiver
// no dependencies; used by slfr_apb_regs and sync_length_frame_receiver
package slfr_pkg;

  localparam logic [7:0]  SYNC_BYTE      = 8'h16;
  localparam logic [7:0]  END_BYTE       = 8'h0d;
  localparam logic [16:0] NO_LENGTH      = 17'h1ffff;
  localparam logic [16:0] HDR_COUNT      = 17'd7;
  localparam logic [7:0]  OVERHEAD_RESET = 8'd8;

  // register indexes on the configuration port
  localparam logic REG_FRAME_OVERHEAD = 1'b0;

  // one result transaction
  typedef struct packed {
    logic [15:0] payload_length;
    logic [15:0] command_code;
    logic        checksum_ok;
    logic        frame_done;
    logic        byte_kept;
    logic [10:0] byte_position;
  } rslt_t;

endpackage

// ===== hw/rtl/slfr_apb_regs.sv =====
`timescale 1ns / 1ps
// slfr_apb_regs: APB register file holding frame_overhead
// depends on slfr_pkg
module slfr_apb_regs (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  frame_overhead
);

  logic reg_index;
  logic wr_en;

  assign reg_index = paddr[2];
  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_overhead <= slfr_pkg::OVERHEAD_RESET;
    end else if (wr_en && reg_index == slfr_pkg::REG_FRAME_OVERHEAD) begin
      frame_overhead <= pwdata[7:0];
    end
  end

  always_comb begin
    unique case (reg_index)
      slfr_pkg::REG_FRAME_OVERHEAD: prdata = 32'(frame_overhead);
      default:                      prdata = 32'd0;
    endcase
  end

endmodule

// ===== hw/rtl/sync_length_frame_receiver.sv =====
`timescale 1ns / 1ps
// sync_length_frame_receiver: byte-stream deframer with sync, length and checksum
// depends on slfr_pkg and slfr_apb_regs
//
// Usage:
//   s_axis carries one received byte per transaction in s_tdata[7:0].
//   m_axis returns one result transaction for every accepted byte: its position in
//   the frame, whether it was kept, and the captured command and length words.
//   m_tlast marks the byte that completes a frame (0x0d at the expected total);
//   m_tuser[1] then gives the checksum verdict. frame_overhead sits at APB byte
//   address 0; the user must see it is written only while idle; no logic checks it.
// Timing:
//   m_tvalid is set at the accepting edge; one byte per cycle is sustained
//   while m_tready is high, set by the single state update plus output register.
//   The result register frees as it is taken, so s_tready stays high while
//   m_tready is high.
// Reset:
//   synchronous rst clears the frame state, sets frame_overhead to 8 and
//   empties the output register.
// Stall:
//   with m_tready low and a result held, s_tready drops until it is taken.
module sync_length_frame_receiver #(
  parameter int BUFFER_LIMIT = 1024
) (
  input  logic        clk,
  input  logic        rst,
  // apb configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // byte input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  // result output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [10:0] byte_position, [26:11] command_code,
                                 // [42:27] payload_length, [47:43] zero
  output logic        m_tlast,   // frame_done
  output logic [1:0]  m_tuser    // [0] byte_kept, [1] checksum_ok
);

  localparam int PW = $clog2(BUFFER_LIMIT + 1);

  logic [7:0] frame_overhead;

  slfr_apb_regs u_regs (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .frame_overhead (frame_overhead)
  );

  // frame state
  logic [PW-1:0] pos,            pos_next;
  logic [16:0]   expected_total, expected_total_next;
  logic [7:0]    running_sum,    running_sum_next;
  logic [7:0]    previous_byte,  previous_byte_next;
  logic [15:0]   captured_command, captured_command_next;
  logic [15:0]   captured_length,  captured_length_next;

  logic           accept;
  logic [16:0]    count;
  logic [7:0]     rx;
  slfr_pkg::rslt_t rslt_next, rslt;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign rx       = s_tdata;
  assign count    = 17'(pos) + 17'd1;

  always_comb begin
    pos_next              = pos;
    expected_total_next   = expected_total;
    running_sum_next      = running_sum;
    previous_byte_next    = previous_byte;
    captured_command_next = captured_command;
    captured_length_next  = captured_length;
    rslt_next             = '0;
    rslt_next.byte_kept   = 1'b1;

    if (count > slfr_pkg::HDR_COUNT) begin
      if (rx == slfr_pkg::END_BYTE && count == expected_total) begin
        rslt_next.frame_done  = 1'b1;
        rslt_next.checksum_ok = (running_sum == previous_byte);
        pos_next              = '0;
        expected_total_next   = slfr_pkg::NO_LENGTH;
        running_sum_next      = '0;
        previous_byte_next    = '0;
      end else if (count > expected_total || count > 17'(BUFFER_LIMIT)) begin
        // overrun: resync
        rslt_next.byte_kept = 1'b0;
        pos_next            = '0;
        expected_total_next = slfr_pkg::NO_LENGTH;
        running_sum_next    = '0;
        previous_byte_next  = '0;
      end else begin
        running_sum_next   = running_sum + previous_byte;
        previous_byte_next = rx;
        pos_next           = PW'(count);
      end
    end else if ((count == 17'd1 || count == 17'd2) && rx != slfr_pkg::SYNC_BYTE) begin
      // sync mismatch, byte is dropped without rescan
      rslt_next.byte_kept = 1'b0;
      pos_next            = '0;
      running_sum_next    = '0;
      previous_byte_next  = '0;
    end else begin
      case (count)
        17'd3: captured_command_next[7:0]  = rx;
        17'd4: captured_command_next[15:8] = rx;
        17'd5: captured_length_next[7:0]   = rx;
        17'd6: begin
          captured_length_next[15:8] = rx;
          expected_total_next = 17'({rx, captured_length[7:0]}) + 17'(frame_overhead);
        end
        default: ;
      endcase
      running_sum_next   = running_sum + previous_byte;
      previous_byte_next = rx;
      pos_next           = PW'(count);
    end

    rslt_next.byte_position  = 11'(pos);
    rslt_next.command_code   = captured_command_next;
    rslt_next.payload_length = captured_length_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos              <= '0;
      expected_total   <= slfr_pkg::NO_LENGTH;
      running_sum      <= '0;
      previous_byte    <= '0;
      captured_command <= '0;
      captured_length  <= '0;
    end else if (accept) begin
      pos              <= pos_next;
      expected_total   <= expected_total_next;
      running_sum      <= running_sum_next;
      previous_byte    <= previous_byte_next;
      captured_command <= captured_command_next;
      captured_length  <= captured_length_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rslt <= rslt_next;
    end
  end

  assign m_tdata = {5'd0, rslt.payload_length, rslt.command_code, rslt.byte_position};
  assign m_tlast = rslt.frame_done;
  assign m_tuser = {rslt.checksum_ok, rslt.byte_kept};

  // checks
  a_ok_needs_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tlast)
    else $error("checksum_ok without frame_done");

  a_done_is_kept: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser[0])
    else $error("frame_done on a discarded byte");

  a_pos_in_buffer: assert property (@(posedge clk) disable iff (rst)
    17'(pos) <= 17'(BUFFER_LIMIT))
    else $error("position beyond buffer limit");

  a_no_length_in_header: assert property (@(posedge clk) disable iff (rst)
    17'(pos) < 17'd6 |-> expected_total == slfr_pkg::NO_LENGTH)
    else $error("expected total set before length captured");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted byte produced no result");

endmodule
